[hdl/rtse_pkg.sv]
// rtse_pkg: shared types and constants for the session record table.
// No dependencies.
`default_nettype none
package rtse_pkg;
   localparam int TYPE_W  = 8;
   localparam int TIME_W  = 32;
   localparam int WCNT_W  = 16;
   localparam int REC_W   = 120;
   localparam int CMD_W   = 3;
   localparam int SEL_W   = 5;
   localparam int TOT_W   = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_COUNT  = 3'd1,
      CMD_GET    = 3'd2,
      CMD_MARK   = 3'd3,
      CMD_MATCH  = 3'd4,
      CMD_PURGE  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_SCAN,
      ST_MOVE,
      ST_DONE,
      ST_RSP
   } state_type;

   // record packed as {type, start, dur, wcount, wdur}
   typedef logic [REC_W-1:0] rec_type;
endpackage
`default_nettype wire

[hdl/rtse_mem.sv]
// rtse_mem: record store (one write port, one registered read port) plus
// per-slot sent flags. Depends on rtse_pkg.
`default_nettype none
module rtse_mem
   import rtse_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire rec_type       wdata,
   input  wire logic          wsent,
   input  wire logic [AW-1:0] raddr,
   output rec_type            rdata,
   output logic               rsent
);
   rec_type mem [DEPTH];
   logic    sent_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr]      <= wdata;
         sent_mem[waddr] <= wsent;
      end
      rdata <= mem[raddr];
      rsent <= sent_mem[raddr];
   end
endmodule
`default_nettype wire

[hdl/record_table_with_sent_eviction_top.sv]
// Top level of the session record table: sequencer driving one memory
// read/compare/write path. Depends on rtse_pkg and rtse_mem.
//
// Ordered table of DEPTH session records with a sent mark each, slot 0
// oldest. One command is in flight at a time: req_ready is high only in
// idle. A walking command visits the slots it needs through the single
// registered read port, each slot in a read state and then an examine /
// write-back state. Count, a non-full append and unknown codes go from
// idle straight to the done and response states; mark slot reads and
// examines its slot when in range; get / match / purge walk the occupied
// slots. A full append first searches for the victim and then shifts
// the later slots down. The result beat sits in an output register
// until rsp_ready. unsent_total is kept as a running counter so
// count-unsent needs no walk. No clearing pass: slots past the occupancy
// are never read.
`default_nettype none
module record_table_with_sent_eviction_top
   import rtse_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [2:0]    req_command,
   input  wire logic [4:0]    req_slot_or_ordinal,
   input  wire logic [7:0]    req_rec_type,
   input  wire logic [31:0]   req_rec_start_time,
   input  wire logic [31:0]   req_rec_duration,
   input  wire logic [15:0]   req_rec_wrong_count,
   input  wire logic [31:0]   req_rec_wrong_duration,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_ok,
   output logic [5:0]         rsp_unsent_total,
   output logic [5:0]         rsp_occupancy,
   output logic [4:0]         rsp_found_slot,
   output logic [7:0]         rsp_out_type,
   output logic [31:0]        rsp_out_start_time,
   output logic [31:0]        rsp_out_duration,
   output logic [15:0]        rsp_out_wrong_count,
   output logic [31:0]        rsp_out_wrong_duration,
   output logic               rsp_marker_request,
   output logic               rsp_evicted
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > SEL_W) ? CW : SEL_W;   // slot/count compare width

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   rec_type          pat_ff, pat_in;
   logic [CW-1:0]    cnt_ff, cnt_in;    // occupancy
   logic [CW-1:0]    uns_ff, uns_in;    // unsent total
   logic [CW-1:0]    rd_ff, rd_in;      // read pointer
   logic [CW-1:0]    wr_ff, wr_in;      // write pointer (purge/shift)
   logic [CW-1:0]    seen_ff, seen_in;
   logic             shift_ff, shift_in; // append: shift phase
   logic             ok_ff, ok_in;
   logic             ev_ff, ev_in;
   logic             mk_ff, mk_in;
   logic [AW-1:0]    slot_ff, slot_in;
   rec_type          out_ff, out_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   rec_type       wdata, rdata;
   logic          wsent, rsent;

   rtse_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock, .we, .waddr, .wdata, .wsent, .raddr, .rdata, .rsent
   );

   rec_type req_rec;
   assign req_rec = {req_rec_type, req_rec_start_time, req_rec_duration,
                     req_rec_wrong_count, req_rec_wrong_duration};

   assign req_ready = (state_ff == ST_IDLE);
   assign raddr     = rd_ff[AW-1:0];

   logic [TIME_W-1:0] rd_start;
   assign rd_start = rdata[REC_W-TYPE_W-1 -: TIME_W];

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; sel_in = sel_ff; pat_in = pat_ff;
      cnt_in = cnt_ff; uns_in = uns_ff; rd_in = rd_ff; wr_in = wr_ff;
      seen_in = seen_ff; shift_in = shift_ff; ok_in = ok_ff; ev_in = ev_ff;
      mk_in = mk_ff; slot_in = slot_ff; out_in = out_ff;
      we = 1'b0; waddr = wr_ff[AW-1:0]; wdata = rdata; wsent = rsent;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               sel_in = req_slot_or_ordinal;
               pat_in = req_rec;
               ok_in = 1'b0; ev_in = 1'b0; mk_in = 1'b0;
               slot_in = '0; out_in = '0;
               rd_in = '0; wr_in = '0; seen_in = '0; shift_in = 1'b0;
               state_in = ST_DONE;
               case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     ok_in = 1'b1;
                     if (cnt_ff >= CW'(DEPTH)) begin
                        ev_in = 1'b1;
                        state_in = ST_RD;
                     end
                  end
                  CMD_COUNT: ok_in = (uns_ff != '0);
                  CMD_MARK: begin
                     if (XW'(req_slot_or_ordinal) < XW'(cnt_ff)) begin
                        rd_in = CW'(req_slot_or_ordinal);
                        state_in = ST_RD;
                     end
                  end
                  CMD_GET, CMD_MATCH, CMD_PURGE:
                     if (cnt_ff != '0) state_in = ST_RD;
                  default: ;
               endcase
            end
         end
         ST_RD: state_in = ST_SCAN;   // read data valid next cycle
         ST_SCAN: begin
            state_in = ST_RD;
            case (cmd_ff)
               CMD_APPEND: begin
                  if (!shift_ff) begin
                     // find victim: first sent, else slot 0
                     if (rsent || rd_ff == cnt_ff - 1'b1) begin
                        wr_in = rsent ? rd_ff : '0;
                        if (!rsent) uns_in = uns_ff - 1'b1;
                        shift_in = 1'b1;
                        rd_in = (rsent ? rd_ff : '0) + 1'b1;
                        if ((rsent ? rd_ff : '0) + 1'b1 >= cnt_ff) begin
                           cnt_in = cnt_ff - 1'b1;
                           state_in = ST_DONE;
                        end
                     end else rd_in = rd_ff + 1'b1;
                  end else begin
                     we = 1'b1;
                     wr_in = wr_ff + 1'b1;
                     rd_in = rd_ff + 1'b1;
                     if (rd_ff + 1'b1 >= cnt_ff) begin
                        cnt_in = cnt_ff - 1'b1;
                        state_in = ST_DONE;
                     end
                  end
               end
               CMD_GET: begin
                  if (!rsent && XW'(seen_ff) == XW'(sel_ff)) begin
                     ok_in = 1'b1; slot_in = rd_ff[AW-1:0]; out_in = rdata;
                     state_in = ST_DONE;
                  end else begin
                     if (!rsent) seen_in = seen_ff + 1'b1;
                     rd_in = rd_ff + 1'b1;
                     if (rd_ff + 1'b1 >= cnt_ff) state_in = ST_DONE;
                  end
               end
               CMD_MARK, CMD_MATCH: begin
                  if (!rsent && (cmd_ff == CMD_MARK || rdata == pat_ff)) begin
                     we = 1'b1; waddr = rd_ff[AW-1:0]; wsent = 1'b1;
                     ok_in = 1'b1; slot_in = rd_ff[AW-1:0];
                     uns_in = uns_ff - 1'b1;
                     if (rd_start != '0) begin
                        mk_in = 1'b1;
                        out_in[REC_W-TYPE_W-1 -: TIME_W] = rd_start;
                     end
                     state_in = ST_DONE;
                  end else if (cmd_ff == CMD_MARK || rd_ff + 1'b1 >= cnt_ff) begin
                     state_in = ST_DONE;
                  end else rd_in = rd_ff + 1'b1;
               end
               CMD_PURGE: begin
                  if (!rsent) begin
                     we = 1'b1; wr_in = wr_ff + 1'b1;
                  end
                  rd_in = rd_ff + 1'b1;
                  if (rd_ff + 1'b1 >= cnt_ff) begin
                     cnt_in = rsent ? wr_ff : wr_ff + 1'b1;
                     ok_in = rsent || (wr_ff != rd_ff);
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DONE: begin
            if (cmd_ff == CMD_APPEND) begin
               we = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = pat_ff; wsent = 1'b0;
               cnt_in = cnt_ff + 1'b1; uns_in = uns_ff + 1'b1;
            end
            state_in = ST_RSP;
         end
         ST_RSP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         uns_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         uns_ff   <= uns_in;
      end
      cmd_ff <= cmd_in; sel_ff <= sel_in; pat_ff <= pat_in;
      rd_ff <= rd_in; wr_ff <= wr_in; seen_ff <= seen_in; shift_ff <= shift_in;
      ok_ff <= ok_in; ev_ff <= ev_in; mk_ff <= mk_in; slot_ff <= slot_in;
      out_ff <= out_in;
   end

   assign rsp_valid              = (state_ff == ST_RSP);
   assign rsp_ok                 = ok_ff;
   assign rsp_unsent_total       = TOT_W'(uns_ff);
   assign rsp_occupancy          = TOT_W'(cnt_ff);
   assign rsp_found_slot         = SEL_W'(slot_ff);
   assign rsp_out_type           = out_ff[REC_W-1 -: TYPE_W];
   assign rsp_out_start_time     = out_ff[REC_W-TYPE_W-1 -: TIME_W];
   assign rsp_out_duration       = out_ff[TIME_W+WCNT_W+TIME_W-1 -: TIME_W];
   assign rsp_out_wrong_count    = out_ff[TIME_W+WCNT_W-1 -: WCNT_W];
   assign rsp_out_wrong_duration = out_ff[TIME_W-1:0];
   assign rsp_marker_request     = mk_ff;
   assign rsp_evicted            = ev_ff;
endmodule
`default_nettype wire
